### sv/tfd_pkg.sv
// Shared constants, types and codes for the typed frame deframer.
`timescale 1ns / 1ps
package tfd_pkg;

    localparam int MAX_LEN    = 64;
    localparam int CHANNELS   = 2;
    localparam int RES_LIMIT  = 64;
    localparam int FIFO_DEPTH = 2;

    localparam int FILL_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(RES_LIMIT + 1);
    localparam int ADDR_W  = $clog2(CHANNELS * MAX_LEN);
    localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int COUNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_CODE = 2'd0;
    localparam logic [1:0] CFG_END_CODE   = 2'd1;
    localparam logic [1:0] CFG_TEXT_TYPE  = 2'd2;
    localparam logic [1:0] CFG_HOST_TYPE  = 2'd3;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_HOST  = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } back_state_t;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        logic             ch;
        kind_t            kind;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

### sv/typed_frame_deframer_unit.sv
// Top level of the typed frame deframer: front end, command queue and back end.
// A closing word gives a host request, abort flag or empty message on the output once it has
// passed the command queue and the output register; a text payload is read from the store word
// by word, with a fetch step and then a send step for each word.
// Input words are taken one per cycle while the command queue has room; a word to be stored
// also waits while any command is queued or a text payload is being sent. Reset clears
// control state and the code registers; the frame store is not cleared, as only bytes
// written in the open frame are read.
`timescale 1ns / 1ps
module typed_frame_deframer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [8] has_byte, rest zero
    output logic [2:0]  m_tuser,   // [0] out_channel, [2:1] kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    tfd_pkg::fifo_stat_t fifo_stat;
    tfd_pkg::cmd_t       push_cmd;
    tfd_pkg::cmd_t       pop_cmd;
    tfd_pkg::store_wr_t  wr;
    logic                push;
    logic                pop;
    logic                back_busy;

    tfd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .channel   (s_tuser[0]),
        .rx_byte   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fifo_stat (fifo_stat),
        .back_busy (back_busy),
        .push      (push),
        .push_cmd  (push_cmd),
        .wr        (wr)
    );

    tfd_cmd_fifo u_cmd_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (fifo_stat)
    );

    tfd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .fifo_stat (fifo_stat),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .busy      (back_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### sv/tfd_front.sv
// Front end: accepts received words, tracks per-channel frames and issues commands.
`timescale 1ns / 1ps
module tfd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 channel,
    input  logic [7:0]           rx_byte,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  tfd_pkg::fifo_stat_t  fifo_stat,
    input  logic                 back_busy,
    output logic                 push,
    output tfd_pkg::cmd_t        push_cmd,
    output tfd_pkg::store_wr_t   wr
);

    logic [7:0] start_code_reg;
    logic [7:0] end_code_reg;
    logic [7:0] text_type_reg;
    logic [7:0] host_type_reg;

    logic                      in_frame_reg [tfd_pkg::CHANNELS];
    logic [tfd_pkg::FILL_W-1:0] fill_reg    [tfd_pkg::CHANNELS];
    logic [7:0]                type_reg     [tfd_pkg::CHANNELS];
    logic [7:0]                lenb_reg     [tfd_pkg::CHANNELS];

    logic                       ch_ok;
    logic                       open_frame;
    logic [tfd_pkg::FILL_W-1:0] fill;
    logic                       is_start;
    logic                       is_end;
    logic                       is_zero;
    logic                       data_byte;
    logic                       store_byte;
    logic                       overflow;
    logic                       is_close;
    logic                       drain_busy;
    logic                       accept;
    logic [8:0]                 avail;
    logic [8:0]                 cnt;
    logic                       type_text;
    logic                       type_host;

    always_comb
    begin
        ch_ok      = (32'(channel) < tfd_pkg::CHANNELS);
        open_frame = in_frame_reg[channel] && ch_ok;
        fill       = fill_reg[channel];
        is_start   = (rx_byte == start_code_reg);
        is_end     = (rx_byte == end_code_reg);
        is_zero    = (rx_byte == 8'd0);
        data_byte  = open_frame && !is_start && !is_end && !is_zero;
        store_byte = data_byte && (fill < tfd_pkg::FILL_W'(tfd_pkg::MAX_LEN - 1));
        overflow   = data_byte && (fill == tfd_pkg::FILL_W'(tfd_pkg::MAX_LEN - 1));
        is_close   = open_frame && !is_start && is_end;
        type_text  = (type_reg[channel] == text_type_reg);
        type_host  = (type_reg[channel] == host_type_reg);

        // The store must not be overwritten while a text payload still waits to be read.
        drain_busy = !fifo_stat.empty || back_busy;
        s_tready   = !fifo_stat.full && !(store_byte && drain_busy);
        accept     = s_tvalid && s_tready;

        // Payload length clamped to the bytes after the length byte and to the result limit.
        avail = 9'(fill) - 9'd2;
        cnt   = {1'b0, lenb_reg[channel]};
        if (fill < tfd_pkg::FILL_W'(2))
        begin
            cnt = 9'd0;
        end
        else if (cnt > avail)
        begin
            cnt = avail;
        end
        if (cnt > 9'(tfd_pkg::RES_LIMIT))
        begin
            cnt = 9'(tfd_pkg::RES_LIMIT);
        end

        push_cmd.ch   = channel;
        push_cmd.len  = tfd_pkg::LEN_W'(cnt);
        push_cmd.kind = overflow  ? tfd_pkg::KIND_ABORT :
                        type_text ? tfd_pkg::KIND_TEXT  : tfd_pkg::KIND_HOST;
        push = accept && (overflow ||
               (is_close && (fill != '0) &&
                (type_text || (type_host && (fill == tfd_pkg::FILL_W'(1))))));

        wr.en   = accept && store_byte;
        wr.addr = tfd_pkg::ADDR_W'(32'(channel) * tfd_pkg::MAX_LEN) + tfd_pkg::ADDR_W'(fill);
        wr.data = rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= '0;
            end_code_reg   <= '0;
            text_type_reg  <= '0;
            host_type_reg  <= '0;
            for (int i = 0; i < tfd_pkg::CHANNELS; i++)
            begin
                in_frame_reg[i] <= 1'b0;
                fill_reg[i]     <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tfd_pkg::CFG_START_CODE: start_code_reg <= cfg_data;
                    tfd_pkg::CFG_END_CODE:   end_code_reg   <= cfg_data;
                    tfd_pkg::CFG_TEXT_TYPE:  text_type_reg  <= cfg_data;
                    tfd_pkg::CFG_HOST_TYPE:  host_type_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && ch_ok)
            begin
                if (!in_frame_reg[channel] && is_start)
                begin
                    in_frame_reg[channel] <= 1'b1;
                    fill_reg[channel]     <= '0;
                end
                else if (is_close || overflow)
                begin
                    in_frame_reg[channel] <= 1'b0;
                    fill_reg[channel]     <= '0;
                end
                else if (store_byte)
                begin
                    fill_reg[channel] <= fill + tfd_pkg::FILL_W'(1);
                end
            end
        end
    end

    // Type and length bytes are kept aside so the close decision needs no store read.
    always_ff @(posedge clk)
    begin
        if (wr.en && (fill == '0))
        begin
            type_reg[channel] <= rx_byte;
        end
        if (wr.en && (fill == tfd_pkg::FILL_W'(1)))
        begin
            lenb_reg[channel] <= rx_byte;
        end
    end

    a_no_write_during_drain: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !drain_busy)
        else $error("frame store written while a payload drain is pending");

endmodule

### sv/tfd_cmd_fifo.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module tfd_cmd_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tfd_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output tfd_pkg::cmd_t        pop_cmd,
    output tfd_pkg::fifo_stat_t  stat
);

    tfd_pkg::cmd_t               slot_reg [tfd_pkg::FIFO_DEPTH];
    logic [tfd_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [tfd_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [tfd_pkg::COUNT_W-1:0] count_reg;
    logic [tfd_pkg::PTR_W-1:0]   wr_ptr_next;
    logic [tfd_pkg::PTR_W-1:0]   rd_ptr_next;

    always_comb
    begin
        stat.full  = (count_reg == tfd_pkg::COUNT_W'(tfd_pkg::FIFO_DEPTH));
        stat.empty = (count_reg == '0);
        pop_cmd    = slot_reg[rd_ptr_reg];
        wr_ptr_next = (wr_ptr_reg == tfd_pkg::PTR_W'(tfd_pkg::FIFO_DEPTH - 1)) ?
                      '0 : wr_ptr_reg + tfd_pkg::PTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == tfd_pkg::PTR_W'(tfd_pkg::FIFO_DEPTH - 1)) ?
                      '0 : rd_ptr_reg + tfd_pkg::PTR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + tfd_pkg::COUNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - tfd_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("command popped from an empty queue");

endmodule

### sv/tfd_back.sv
// Back end: holds the frame store, runs commands and drives the result stream.
`timescale 1ns / 1ps
module tfd_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tfd_pkg::store_wr_t   wr,
    input  tfd_pkg::fifo_stat_t  fifo_stat,
    input  tfd_pkg::cmd_t        pop_cmd,
    output logic                 pop,
    output logic                 busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,  // [7:0] payload_byte, [8] has_byte, rest zero
    output logic [2:0]           m_tuser,  // [0] out_channel, [2:1] kind
    output logic                 m_tlast
);

    logic [7:0] store_mem [tfd_pkg::CHANNELS * tfd_pkg::MAX_LEN];
    logic [7:0] rdata_reg;

    tfd_pkg::back_state_t       state_reg;
    tfd_pkg::back_state_t       state_next;
    tfd_pkg::cmd_t              cmd_reg;
    tfd_pkg::cmd_t              cmd_next;
    logic [tfd_pkg::LEN_W-1:0]  idx_reg;
    logic [tfd_pkg::LEN_W-1:0]  idx_next;
    logic [tfd_pkg::LEN_W-1:0]  idx_inc;

    logic                       rd_en;
    logic [tfd_pkg::ADDR_W-1:0] rd_addr;

    logic                       out_valid_reg;
    logic                       out_ch_reg;
    tfd_pkg::kind_t             out_kind_reg;
    logic [7:0]                 out_byte_reg;
    logic                       out_has_reg;
    logic                       out_last_reg;

    logic                       out_free;
    logic                       load;
    logic                       ld_ch;
    tfd_pkg::kind_t             ld_kind;
    logic [7:0]                 ld_byte;
    logic                       ld_has;
    logic                       ld_last;

    always_comb
    begin
        out_free   = !out_valid_reg || m_tready;
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        idx_inc    = idx_reg + tfd_pkg::LEN_W'(1);
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = tfd_pkg::ADDR_W'(32'(cmd_reg.ch) * tfd_pkg::MAX_LEN)
                   + tfd_pkg::ADDR_W'(idx_reg) + tfd_pkg::ADDR_W'(2);
        load       = 1'b0;
        ld_ch      = cmd_reg.ch;
        ld_kind    = tfd_pkg::KIND_TEXT;
        ld_byte    = 8'd0;
        ld_has     = 1'b0;
        ld_last    = 1'b1;

        unique case (state_reg)
            tfd_pkg::ST_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    if ((pop_cmd.kind == tfd_pkg::KIND_TEXT) && (pop_cmd.len != '0))
                    begin
                        pop        = 1'b1;
                        cmd_next   = pop_cmd;
                        idx_next   = '0;
                        state_next = tfd_pkg::ST_FETCH;
                    end
                    else if (out_free)
                    begin
                        // Host request, abort flag or empty text message: a single word.
                        pop     = 1'b1;
                        load    = 1'b1;
                        ld_ch   = pop_cmd.ch;
                        ld_kind = pop_cmd.kind;
                    end
                end
            end
            tfd_pkg::ST_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = tfd_pkg::ST_SEND;
            end
            tfd_pkg::ST_SEND:
            begin
                if (out_free)
                begin
                    load     = 1'b1;
                    ld_byte  = rdata_reg;
                    ld_has   = 1'b1;
                    ld_last  = (idx_inc == cmd_reg.len);
                    idx_next = idx_inc;
                    state_next = ld_last ? tfd_pkg::ST_IDLE : tfd_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = tfd_pkg::ST_IDLE;
            end
        endcase

        busy = (state_reg != tfd_pkg::ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        if (load)
        begin
            out_ch_reg   <= ld_ch;
            out_kind_reg <= ld_kind;
            out_byte_reg <= ld_byte;
            out_has_reg  <= ld_has;
            out_last_reg <= ld_last;
        end
    end

    // Frame store: one write port from the front end, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_has_reg, out_byte_reg};
    assign m_tuser  = {out_kind_reg, out_ch_reg};
    assign m_tlast  = out_last_reg;

    a_fetch_then_send: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tfd_pkg::ST_FETCH) |=> (state_reg == tfd_pkg::ST_SEND))
        else $error("store read not followed by a send step");

    a_send_loads_byte: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == tfd_pkg::ST_SEND) && out_free) |=> (out_valid_reg && out_has_reg))
        else $error("payload word not presented after a send step");

endmodule
